// ===== sv/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants for the Poisson quantile unit
// Widths, search bound, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package pic_pkg;

  // search bound: counts 0 .. SEARCH_LIMIT-1 are tested
  localparam int SEARCH_LIMIT = 100;
  localparam int K_W          = $clog2(SEARCH_LIMIT + 1);

  // field widths
  localparam int P_W      = 48;           // target probability, Q0.48
  localparam int Q_W      = 49;           // term and running sum, Q1.48
  localparam int LAM_W    = 22;           // lambda, 16 fraction bits
  localparam int LAM_FRAC = 16;
  localparam int OUT_W    = 7;

  // configuration port
  localparam int CFG_W     = Q_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_LAMBDA  = 2'd0,
    REG_EXP_NEG_RATE = 2'd1
  } cfg_reg_t;

  // product term * lambda, split into chunks of the term
  localparam int PROD_W     = Q_W + LAM_W;
  localparam int SCALED_W   = PROD_W - LAM_FRAC;
  localparam int MUL_CHUNKS = 3;
  localparam int CH_W       = (Q_W + MUL_CHUNKS - 1) / MUL_CHUNKS;
  localparam int CHS_W      = $clog2(MUL_CHUNKS);
  localparam int PP_W       = CH_W + LAM_W;

  // divider: quotient bits retired per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (SCALED_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;

  // shared step counter covers both multiply and divide passes
  localparam int CNT_W = $clog2(DIV_STEPS + MUL_CHUNKS + 1);

  localparam logic [Q_W-1:0] Q_MAX      = {Q_W{1'b1}};
  localparam logic [Q_W-1:0] EXP_RESET  = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== sv/poisson_inverse_cdf.sv =====
// ----------------------------------------------------------------------------
// poisson_inverse_cdf: Poisson quantile by a sequential CDF scan
// Accumulates Poisson terms from e^-lambda until the running sum reaches the
// target probability; each next term comes from a shared chunked multiplier
// and a radix-256 divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | prob_in     (48 b, Q0.48)
//  out     | out_valid / out_stall| quantile_k  (7 b)
//  cfg     | cfg_we               | cfg_index, cfg_data (49 b)
//
//  Each count tested takes one add and compare, a pass through the 17x22
//  multiplier (three partial products and accumulate) and the divider
//  steps. The full search tests at most 100 counts.
//  in_stall is high while a word is being worked on; one finished result may
//  wait in the output register while the next word is taken.
//  rst (synchronous) resets the sequencer, out_valid, lambda and e^-lambda.
// ----------------------------------------------------------------------------
module poisson_inverse_cdf
  import pic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input word
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [P_W-1:0]       prob_in,
  // result word
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     quantile_k
);

  state_t state, state_next;

  logic [LAM_W-1:0]  rate_lambda;
  logic [Q_W-1:0]    exp_neg_rate;

  logic [P_W-1:0]    prob;
  logic [Q_W-1:0]    term;
  logic [Q_W-1:0]    sum;
  logic [K_W-1:0]    k;
  logic [K_W-1:0]    result;
  logic [CNT_W-1:0]  cnt;
  logic [PP_W-1:0]   prod;
  logic [PROD_W-1:0] acc;
  logic [DIV_W-1:0]  dq;
  logic [K_W-1:0]    rem;

  logic [Q_W:0]                 sum_wide;
  logic [Q_W-1:0]               sum_sat;
  logic                         reached;
  logic [CH_W*MUL_CHUNKS-1:0]   term_pad;
  logic [CHS_W-1:0]             chunk_sel;
  logic [CH_W-1:0]              chunk;
  logic [PROD_W-1:0]            acc_add;
  logic [K_W-1:0]               divisor;
  logic [DIV_W-1:0]             dq_next;
  logic [K_W-1:0]               rem_next;
  logic [K_W:0]                 r2;
  logic [Q_W-1:0]               quot_sat;
  logic                         out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_lambda  <= '0;
      exp_neg_rate <= EXP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_LAMBDA:  rate_lambda  <= cfg_data[LAM_W-1:0];
        REG_EXP_NEG_RATE: exp_neg_rate <= cfg_data[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // running sum with saturation and compare against the target
  assign sum_wide = {1'b0, sum} + {1'b0, term};
  assign sum_sat  = sum_wide[Q_W] ? Q_MAX : sum_wide[Q_W-1:0];
  assign reached  = sum_sat >= {1'b0, prob};

  // chunked multiply, most significant chunk first
  assign term_pad  = (CH_W*MUL_CHUNKS)'(term);
  assign chunk_sel = CHS_W'(MUL_CHUNKS - 1) - cnt[CHS_W-1:0];
  assign chunk     = term_pad[chunk_sel*CH_W +: CH_W];
  assign acc_add   = (acc << CH_W) + PROD_W'(prod);

  // radix-256 long division by k+1: eight restoring steps per cycle
  assign divisor = k + K_W'(1);

  always_comb begin
    dq_next  = dq;
    rem_next = rem;
    r2       = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2      = {rem_next, dq_next[DIV_W-1]};
      dq_next = {dq_next[DIV_W-2:0], 1'b0};
      if (r2 >= {1'b0, divisor}) begin
        r2         = r2 - {1'b0, divisor};
        dq_next[0] = 1'b1;
      end
      rem_next = r2[K_W-1:0];
    end
  end

  assign quot_sat = (|dq_next[DIV_W-1:Q_W]) ? Q_MAX : dq_next[Q_W-1:0];

  assign out_free = !out_valid || !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and input stall
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = S_ADD;
      end
      S_ADD: begin
        if (reached || k == K_W'(SEARCH_LIMIT - 1)) state_next = S_DONE;
        else state_next = S_MUL;
      end
      S_MUL: begin
        if (cnt == CNT_W'(MUL_CHUNKS)) state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_ADD;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          prob <= prob_in;
          term <= exp_neg_rate;
          sum  <= '0;
          k    <= '0;
        end
      end
      S_ADD: begin
        sum <= sum_sat;
        cnt <= '0;
        acc <= '0;
        if (reached) result <= k;
        else result <= K_W'(SEARCH_LIMIT);
      end
      S_MUL: begin
        if (cnt != CNT_W'(MUL_CHUNKS)) prod <= chunk * rate_lambda;
        if (cnt != '0) acc <= acc_add;
        if (cnt == CNT_W'(MUL_CHUNKS)) begin
          // keep floor(term*lambda / 2^16) as the dividend
          dq  <= DIV_W'(acc_add[PROD_W-1:LAM_FRAC]);
          rem <= '0;
          cnt <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      S_DIV: begin
        dq  <= dq_next;
        rem <= rem_next;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          term <= quot_sat;
          k    <= k + K_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register: load when the previous word has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) quantile_k <= OUT_W'(result);
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Poisson quantile unit
// Drives target probabilities through the valid/stall input channel, keeps
// its own copy of lambda and e^-lambda, scans the truncated Poisson terms to
// work out each quantile and compares every result word in order. Directed
// corner cases come first, then random phases under several settings, a
// noisy phase with arbitrary register values, a gap-free phase and a phase
// that holds the sender until every answer is back.
// ----------------------------------------------------------------------------
module tb_top;
  import pic_pkg::*;

  // spare register indexes that the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int  DRAIN_CYCLES = 1200;      // longest search plus margin
  localparam real Q48_ONE      = 281474976710656.0;

  typedef struct packed {
    logic [P_W-1:0]   prob;
    logic [OUT_W-1:0] k;
  } quantile_rec_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [P_W-1:0]       prob_in    = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [OUT_W-1:0]     quantile_k;

  // shadow of the configuration registers, reset values
  logic [LAM_W-1:0]     rate_q16     = '0;
  logic [Q_W-1:0]       exp_rate_q48 = EXP_RESET;

  quantile_rec_t        pending_q[$];
  int                   fail_count = 0;
  bit                   no_gaps    = 1'b0;

  poisson_inverse_cdf dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .prob_in    (prob_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .quantile_k (quantile_k)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Quantile predictor: smallest k whose running sum of truncated terms
  // reaches p, else the search bound
  // ---------------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] predict_quantile(input logic [P_W-1:0] p);
    logic [63:0]      term;
    logic [63:0]      total;
    logic [63:0]      scaled;
    logic [63:0]      quot;
    logic [OUT_W-1:0] k_found;
    bit               found;
    term    = 64'(exp_rate_q48);
    total   = '0;
    k_found = OUT_W'(SEARCH_LIMIT);
    found   = 1'b0;
    for (int k = 0; k < SEARCH_LIMIT && !found; k++) begin
      total = total + term;
      if (total > 64'(Q_MAX))
        total = 64'(Q_MAX);
      if (total >= 64'(p)) begin
        k_found = OUT_W'(k);
        found   = 1'b1;
      end else begin
        // term * lambda / 2^16 split so the product stays in 64 bits
        scaled = (term >> LAM_FRAC) * 64'(rate_q16)
               + (((term & 64'hFFFF) * 64'(rate_q16)) >> LAM_FRAC);
        quot   = scaled / 64'(k + 1);
        term   = (quot > 64'(Q_MAX)) ? 64'(Q_MAX) : quot;
      end
    end
    return k_found;
  endfunction

  // e^-lambda in Q1.48 for a Q16 lambda, as software would precompute it
  function automatic logic [Q_W-1:0] exp_q48(input logic [LAM_W-1:0] lam);
    real         lr;
    real         r;
    logic [63:0] v;
    lr = lam;
    r  = $exp(-lr / 65536.0) * Q48_ONE;
    v  = r;
    return (v > 64'(Q_MAX)) ? Q_MAX : v[Q_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted word with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    quantile_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result word: quantile_k=%0d", quantile_k);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (quantile_k !== want.k) begin
          if (fail_count < 10)
            $display("quantile_k wrong: p=%h expected %0d got %0d",
                     want.prob, want.k, quantile_k);
          fail_count++;
        end
      end
    end
  end

  // random back-pressure on the result channel
  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 17);
  end

  // ---------------------------------------------------------------------------
  // Shared drivers; every task is entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // offer one probability word and record its quantile once accepted
  task automatic send_prob(input logic [P_W-1:0] p);
    quantile_rec_t rec;
    while (!no_gaps && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    prob_in  <= p;
    do @(posedge clk); while (in_stall);
    rec.prob = p;
    rec.k    = predict_quantile(p);
    pending_q.push_back(rec);
    @(negedge clk);
  endtask

  // drop valid and hold until every expected word has come back
  task automatic wait_all_answered();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0)
      @(negedge clk);
  endtask

  // write one register; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_RATE_LAMBDA)
      rate_q16 = d[LAM_W-1:0];
    else if (idx == REG_EXP_NEG_RATE)
      exp_rate_q48 = d;
    @(negedge clk);
  endtask

  // load lambda together with its matching e^-lambda
  task automatic set_rate(input logic [LAM_W-1:0] lam);
    write_reg(REG_RATE_LAMBDA, CFG_W'(lam));
    write_reg(REG_EXP_NEG_RATE, exp_q48(lam));
  endtask

  // mostly uniform targets, with the odd extreme or boundary value
  function automatic logic [P_W-1:0] pick_prob();
    int sel;
    sel = $urandom_range(19);
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return exp_rate_q48[P_W-1:0];
      3:       return exp_rate_q48[P_W-1:0] + 1'b1;
      default: return P_W'({$urandom(), $urandom()});
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // corners: reset settings, boundaries at e^-lambda, unreached target,
  // term and sum saturation, lambda above 32 and ignored register indexes
  task automatic test_directed();
    // reset settings: lambda 0, e^-lambda 1.0
    send_prob('0);
    send_prob('1);
    wait_all_answered();

    set_rate(LAM_W'(1 << LAM_FRAC));
    send_prob('0);
    send_prob(P_W'(1));
    send_prob('1);
    send_prob(exp_rate_q48[P_W-1:0]);
    send_prob(exp_rate_q48[P_W-1:0] + 1'b1);
    wait_all_answered();

    set_rate(LAM_W'(32 << LAM_FRAC));
    send_prob(P_W'({$urandom(), $urandom()}));
    send_prob('1);
    wait_all_answered();

    // lambda 0 leaves only the first term: anything above it is never reached
    write_reg(REG_RATE_LAMBDA, '0);
    write_reg(REG_EXP_NEG_RATE, CFG_W'(12345));
    send_prob(P_W'(12345));
    send_prob(P_W'(12346));
    wait_all_answered();

    write_reg(REG_EXP_NEG_RATE, '0);
    send_prob('0);
    send_prob(P_W'(1));
    wait_all_answered();

    // all-ones data masks to the largest lambda; the next term saturates
    write_reg(REG_RATE_LAMBDA, '1);
    write_reg(REG_EXP_NEG_RATE, CFG_W'(1) << (Q_W - 2));
    send_prob('1);
    wait_all_answered();
    write_reg(REG_EXP_NEG_RATE, '1);
    send_prob('1);
    wait_all_answered();

    // lambda above 32 keeps the same search bound
    set_rate(LAM_W'(40 << LAM_FRAC));
    send_prob(P_W'({$urandom(), $urandom()}));
    wait_all_answered();

    // writes to unused indexes must leave the registers alone
    set_rate(LAM_W'(2 << LAM_FRAC));
    write_reg(REG_SPARE_A, '0);
    write_reg(REG_SPARE_B, '1);
    send_prob(exp_rate_q48[P_W-1:0]);
    send_prob(exp_rate_q48[P_W-1:0] + 1'b1);
    wait_all_answered();
  endtask

  // random targets under a run of realistic lambda settings
  task automatic test_random_rates();
    logic [LAM_W-1:0] lam;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       lam = '0;
        1:       lam = LAM_W'(32 << LAM_FRAC);
        2:       lam = LAM_W'(1 << (LAM_FRAC - 1));
        3:       lam = LAM_W'($urandom_range(0, 4 << LAM_FRAC));
        default: lam = LAM_W'($urandom_range(0, 32 << LAM_FRAC));
      endcase
      set_rate(lam);
      for (int i = 0; i < 45; i++)
        send_prob(pick_prob());
      wait_all_answered();
    end
  endtask

  // arbitrary register contents, including out-of-range ones
  task automatic test_noise();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_RATE_LAMBDA, CFG_W'({$urandom(), $urandom()}));
      write_reg(REG_EXP_NEG_RATE, CFG_W'({$urandom(), $urandom()}));
      write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                CFG_W'({$urandom(), $urandom()}));
      for (int i = 0; i < 10; i++)
        send_prob(pick_prob());
      wait_all_answered();
    end
  endtask

  // back-to-back words with no idling on either side
  task automatic test_no_gaps();
    no_gaps = 1'b1;
    set_rate(LAM_W'(8 << LAM_FRAC));
    for (int i = 0; i < 40; i++)
      send_prob(pick_prob());
    wait_all_answered();
    no_gaps = 1'b0;
  endtask

  // hold the sender after every word until its answer is back
  task automatic test_one_at_a_time();
    set_rate(LAM_W'($urandom_range(0, 32 << LAM_FRAC)));
    for (int i = 0; i < 15; i++) begin
      send_prob(pick_prob());
      wait_all_answered();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_rates();
    test_noise();
    test_no_gaps();
    test_one_at_a_time();

    // let any stray word surface before judging
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_q.size() != 0) begin
      $display("%0d expected result words never arrived", pending_q.size());
      fail_count += pending_q.size();
    end

    if (fail_count == 0)
      $display("poisson_inverse_cdf: match");
    else
      $display("poisson_inverse_cdf: mismatch");
    $finish;
  end

  // hang guard
  initial begin
    #40000000;
    $display("timeout waiting for the block");
    $display("poisson_inverse_cdf: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pic_pkg.sv
sv/poisson_inverse_cdf.sv
verif/tb_top.sv
